// ----- hdl/wctt_pkg.sv -----
// ----------------------------------------------------------------------------
// wctt_pkg
// Shared types and constants of the client tracker table: table geometry,
// request codes, result status codes and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package wctt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int MAC_W  = 48;
   localparam int RSSI_W = 8;
   localparam int ENTRY_W = MAC_W + RSSI_W;

   // frame filter constants
   localparam logic [1:0] FRAME_TYPE_DATA = 2'd2;
   localparam int         GROUP_BIT       = 40;

   // request codes
   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // result status codes
   localparam logic [2:0] RS_DROPPED   = 3'd0;
   localparam logic [2:0] RS_UPDATED   = 3'd1;
   localparam logic [2:0] RS_INSERTED  = 3'd2;
   localparam logic [2:0] RS_FULL      = 3'd3;
   localparam logic [2:0] RS_READ      = 3'd4;
   localparam logic [2:0] RS_OUT_RANGE = 3'd5;
   localparam logic [2:0] RS_CLEARED   = 3'd6;

   // one stored table entry
   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [RSSI_W-1:0] rssi;
   } entry_type;

   // write port of the entry store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } store_wr_type;

endpackage

`default_nettype wire

// ----- hdl/wctt_store.sv -----
// ----------------------------------------------------------------------------
// wctt_store
// Entry store of the client table: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module wctt_store
   import wctt_pkg::*;
(
   input  wire logic             clock,
   input  wire store_wr_type     wr,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/wifi_client_tracker_table.sv -----
// ----------------------------------------------------------------------------
// wifi_client_tracker_table
// MAC address learning table for the stations of one access point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: observe a frame header, read one entry or
//   clear the table (request code in req_tuser). An observed frame is kept
//   only if it is a data frame of type 2 with exactly one DS bit set, its
//   BSSID matches csr_wr_data as last written, and the client is unicast.
//   A kept frame is searched linearly in the table; a hit updates the RSSI,
//   a miss appends the client or reports the table as full.
//   rsp_* returns exactly one result per request, status in rsp_tuser.
// Sequence:
//   Dropped, clear and out-of-range read requests go from idle straight to
//   the done state; in-range reads pass through the read state first. A kept
//   frame stays in the scan state until it hits or has compared all clients
//   held; the linear search reads one entry per cycle from the single store
//   read port. The result becomes valid as the block leaves the done state.
//   One request at a time: req_tready is high only while the block is idle.
// Reset and stalls:
//   Reset empties the table and sets the target BSSID to zero. A stalled
//   result is held in the output register; the next request is accepted
//   meanwhile and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_client_tracker_table
   import wctt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // configuration: target BSSID
   input  wire logic         csr_wr_en,
   input  wire logic [47:0]  csr_wr_data,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [0] is_data_packet, [2:1] frame_type, [3] to_ds, [4] from_ds,
   // [52:5] first_address, [100:53] second_address,
   // [108:101] signal_strength, [116:109] read_index, [119:117] zero
   input  wire logic [119:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]   req_tuser,
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] entry_index, [55:8] client_address, [63:56] client_rssi,
   // [72:64] client_count, [79:73] zero
   output logic [79:0]       rsp_tdata,
   // [2:0] status
   output logic [2:0]        rsp_tuser
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // request fields
   logic                     is_data_packet;
   logic [1:0]               frame_type;
   logic                     to_ds;
   logic                     from_ds;
   logic [MAC_W-1:0]         first_address;
   logic [MAC_W-1:0]         second_address;
   logic [RSSI_W-1:0]        signal_strength;
   logic [7:0]               read_index;

   assign is_data_packet  = req_tdata[0];
   assign frame_type      = req_tdata[2:1];
   assign to_ds           = req_tdata[3];
   assign from_ds         = req_tdata[4];
   assign first_address   = req_tdata[52:5];
   assign second_address  = req_tdata[100:53];
   assign signal_strength = req_tdata[108:101];
   assign read_index      = req_tdata[116:109];

   // registers
   state_type         state_ff, state_in;
   logic [MAC_W-1:0]  bssid_ff;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [MAC_W-1:0]  client_ff, client_in;
   logic [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [7:0]        res_index_ff, res_index_in;
   logic [MAC_W-1:0]  res_mac_ff, res_mac_in;
   logic [RSSI_W-1:0] res_rssi_ff, res_rssi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [7:0]        rsp_index_ff;
   logic [MAC_W-1:0]  rsp_mac_ff;
   logic [RSSI_W-1:0] rsp_rssi_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   // store access
   store_wr_type     st_wr;
   logic [IDX_W-1:0] st_rd_addr;
   entry_type        st_rd_data;

   wctt_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // frame filter: address roles and keep decision
   logic             role_ok;
   logic [MAC_W-1:0] frm_bssid;
   logic [MAC_W-1:0] frm_client;
   logic             keep;

   always_comb begin
      role_ok    = to_ds ^ from_ds;
      frm_bssid  = to_ds ? first_address : second_address;
      frm_client = to_ds ? second_address : first_address;
      keep       = is_data_packet && (frame_type == FRAME_TYPE_DATA) && role_ok
                   && (frm_bssid == bssid_ff) && !frm_client[GROUP_BIT];
   end

   assign req_tready = (state_ff == ST_IDLE);

   logic req_fire;
   logic out_free;
   logic hit;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hit      = cmp_valid_ff && (st_rd_data.mac == client_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      client_in     = client_ff;
      rssi_in       = rssi_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_mac_in    = res_mac_ff;
      res_rssi_in   = res_rssi_ff;
      st_rd_addr    = scan_ff[IDX_W-1:0];
      st_wr.en      = 1'b0;
      st_wr.addr    = cmp_idx_ff;
      st_wr.data.mac  = client_ff;
      st_wr.data.rssi = rssi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            res_status_in = RS_DROPPED;
            res_index_in  = '0;
            res_mac_in    = '0;
            res_rssi_in   = '0;
            client_in     = frm_client;
            rssi_in       = signal_strength;
            scan_in       = '0;
            st_rd_addr    = IDX_W'(read_index);
            if (req_fire) begin
               state_in = ST_DONE;
               case (req_tuser)
                  OP_OBSERVE: begin
                     if (keep) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_READ: begin
                     res_index_in = read_index;
                     if ({1'b0, read_index} < used_ff) begin
                        state_in = ST_READ;
                     end else begin
                        res_status_in = RS_OUT_RANGE;
                     end
                  end
                  OP_CLEAR: begin
                     used_in       = '0;
                     res_status_in = RS_CLEARED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // hit: rewrite entry with the new RSSI
               st_wr.en      = 1'b1;
               res_status_in = RS_UPDATED;
               res_index_in  = 8'(cmp_idx_ff);
               res_mac_in    = client_ff;
               res_rssi_in   = rssi_ff;
               state_in      = ST_DONE;
            end else if (scan_ff < used_ff) begin
               // fetch next entry, compare it next cycle
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               // miss: append while room remains
               state_in = ST_DONE;
               if (used_ff < CNT_W'(TABLE_DEPTH)) begin
                  st_wr.en      = 1'b1;
                  st_wr.addr    = used_ff[IDX_W-1:0];
                  used_in       = used_ff + 1'b1;
                  res_status_in = RS_INSERTED;
                  res_index_in  = 8'(used_ff[IDX_W-1:0]);
                  res_mac_in    = client_ff;
                  res_rssi_in   = rssi_ff;
               end else begin
                  res_status_in = RS_FULL;
               end
            end
         end
         ST_READ: begin
            res_status_in = RS_READ;
            res_mac_in    = st_rd_data.mac;
            res_rssi_in   = st_rd_data.rssi;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ((state_ff == ST_DONE) && out_free) || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bssid_ff     <= '0;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bssid_ff <= csr_wr_data;
         end
      end
   end

   // working and pending result registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      client_ff     <= client_in;
      rssi_ff       <= rssi_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_mac_ff    <= res_mac_in;
      res_rssi_ff   <= res_rssi_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_mac_ff    <= res_mac_ff;
         rsp_rssi_ff   <= res_rssi_ff;
         rsp_count_ff  <= used_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, 9'(rsp_count_ff), rsp_rssi_ff, rsp_mac_ff, rsp_index_ff};

endmodule

`default_nettype wire

// ----- tb/sv/wifi_client_tracker_table_tb.sv -----
// ----------------------------------------------------------------------------
// wifi_client_tracker_table_tb
// Self-checking bench for the client tracker table. A short directed table
// covers empty reads, each frame filter rule, insert, update, read back and
// clear. Random phases with several target BSSIDs then follow: small client
// sets that mostly hit, a set large enough to fill the table and overflow
// it, and filtered or malformed frames mixed in. Every result is compared
// field by field with a fixed value or a behavioral model of the table kept
// in the bench, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_client_tracker_table_tb
   import wctt_pkg::*;
();

   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam int         CYCLE_LIMIT     = 3_000_000;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         MAX_IDLE        = 6;

   // directed addresses
   localparam logic [47:0] CLIENT_A = 48'h02_11_22_33_44_55;
   localparam logic [47:0] CLIENT_B = 48'hFE_FF_FF_FF_FF_FF;
   localparam logic [47:0] GROUP_C  = 48'h01_00_5E_00_00_01;
   localparam logic [47:0] OTHER_AP = 48'h00_00_00_00_00_01;
   localparam logic [47:0] ALL_ONES = 48'hFF_FF_FF_FF_FF_FF;

   // one request as seen on req_*
   typedef struct packed {
      logic [1:0]         op;
      logic               is_data;
      logic [1:0]         ftype;
      logic               to_ds;
      logic               from_ds;
      logic [MAC_W-1:0]   addr1;
      logic [MAC_W-1:0]   addr2;
      logic signed [7:0]  rssi;
      logic [7:0]         ridx;
   } tracker_req_type;

   // one result as seen on rsp_*
   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         index;
      logic [MAC_W-1:0]   mac;
      logic signed [7:0]  rssi;
      logic [8:0]         count;
   } tracker_rsp_type;

   typedef struct {
      tracker_req_type req;
      bit              fixed;
      tracker_rsp_type want;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_wr_en;
   logic [47:0]  csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   // bench model of the table
   logic [MAC_W-1:0]  tbl_mac [TABLE_DEPTH];
   logic [RSSI_W-1:0] tbl_rssi [TABLE_DEPTH];
   int                tbl_count;
   logic [MAC_W-1:0]  target_mac;

   tracker_rsp_type   pending_rsp [$];
   directed_row_type  directed_rows [$];
   logic [MAC_W-1:0]  client_pool [$];
   int                pool_next;
   int                fresh_pct;
   int                clear_pct;
   int                max_gap;
   bit                rsp_hold_req;
   int                error_count;
   int                cycle_count;

   wifi_client_tracker_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic tracker_req_type mk_req(input logic [1:0] op, input logic is_data,
                                              input logic [1:0] ftype, input logic to_ds,
                                              input logic from_ds, input logic [47:0] a1,
                                              input logic [47:0] a2, input logic [7:0] rssi,
                                              input logic [7:0] ridx);
      tracker_req_type r;
      r.op = op;
      r.is_data = is_data;
      r.ftype = ftype;
      r.to_ds = to_ds;
      r.from_ds = from_ds;
      r.addr1 = a1;
      r.addr2 = a2;
      r.rssi = rssi;
      r.ridx = ridx;
      return r;
   endfunction

   function automatic tracker_rsp_type mk_rsp(input logic [2:0] status, input logic [7:0] index,
                                              input logic [47:0] mac, input logic [7:0] rssi,
                                              input logic [8:0] count);
      tracker_rsp_type v;
      v.status = status;
      v.index = index;
      v.mac = mac;
      v.rssi = rssi;
      v.count = count;
      return v;
   endfunction

   // filter, search and learn one request; updates the bench table
   function automatic tracker_rsp_type track_client(input tracker_req_type r);
      tracker_rsp_type  v;
      logic [MAC_W-1:0] bssid;
      logic [MAC_W-1:0] client;
      bit               keep;
      int               i;
      v = '0;
      keep = 0;
      bssid = '0;
      client = '0;
      case (r.op)
         OP_READ: begin
            v.index = r.ridx;
            if (r.ridx < tbl_count) begin
               v.status = RS_READ;
               v.mac = tbl_mac[r.ridx];
               v.rssi = tbl_rssi[r.ridx];
            end else begin
               v.status = RS_OUT_RANGE;
            end
         end
         OP_CLEAR: begin
            tbl_count = 0;
            v.status = RS_CLEARED;
         end
         OP_OBSERVE: begin
            v.status = RS_DROPPED;
            if (r.is_data && r.ftype == FRAME_TYPE_DATA && (r.to_ds ^ r.from_ds)) begin
               bssid = r.to_ds ? r.addr1 : r.addr2;
               client = r.to_ds ? r.addr2 : r.addr1;
               keep = (bssid == target_mac) && !client[GROUP_BIT];
            end
            if (keep) begin
               for (i = 0; i < tbl_count; i++) begin
                  if (tbl_mac[i] == client) break;
               end
               if (i < tbl_count) begin
                  tbl_rssi[i] = r.rssi;
                  v = mk_rsp(RS_UPDATED, 8'(i), client, r.rssi, 9'd0);
               end else if (tbl_count < TABLE_DEPTH) begin
                  tbl_mac[i] = client;
                  tbl_rssi[i] = r.rssi;
                  tbl_count++;
                  v = mk_rsp(RS_INSERTED, 8'(i), client, r.rssi, 9'd0);
               end else begin
                  v.status = RS_FULL;
               end
            end
         end
         default: v.status = RS_DROPPED;
      endcase
      v.count = 9'(tbl_count);
      return v;
   endfunction

   // random request: mostly valid frames from the client pool, some reads,
   // clears, filtered frames and pure noise
   function automatic tracker_req_type next_random_frame();
      tracker_req_type  r;
      logic [MAC_W-1:0] client;
      int               roll;
      roll = $urandom_range(0, 99);
      if (pool_next < client_pool.size() &&
          (pool_next == 0 || $urandom_range(0, 99) < fresh_pct)) begin
         client = client_pool[pool_next];
         pool_next++;
      end else begin
         client = client_pool[$urandom_range(0, pool_next - 1)];
      end
      r = mk_req(OP_OBSERVE, 1'b1, FRAME_TYPE_DATA, 1'b0, 1'b0, '0, '0,
                 8'($urandom), 8'($urandom));
      r.to_ds = 1'($urandom_range(0, 1));
      r.from_ds = !r.to_ds;
      r.addr1 = r.to_ds ? target_mac : client;
      r.addr2 = r.to_ds ? client : target_mac;
      if (roll < clear_pct) begin
         r.op = OP_CLEAR;
      end else if (roll < clear_pct + 8) begin
         r.op = OP_READ;
         r.addr1 = 48'({$urandom, $urandom});
         if (tbl_count > 0 && $urandom_range(0, 3) != 0)
            r.ridx = 8'($urandom_range(0, tbl_count - 1));
      end else if (roll >= 90) begin
         if ($urandom_range(0, 1) == 0) begin
            r = mk_req(2'($urandom_range(0, 3)), 1'($urandom), 2'($urandom), 1'($urandom),
                       1'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       8'($urandom), 8'($urandom));
            if (r.op == OP_CLEAR) r.op = OP_UNUSED;
         end else begin
            // well-formed frame broken by a single fault
            case ($urandom_range(0, 4))
               0: r.is_data = 1'b0;
               1: begin
                  r.ftype = 2'($urandom_range(0, 3));
                  if (r.ftype == FRAME_TYPE_DATA) r.ftype = 2'd3;
               end
               2: begin
                  r.to_ds = 1'($urandom_range(0, 1));
                  r.from_ds = r.to_ds;
               end
               3: begin
                  if (r.to_ds) r.addr1[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
                  else r.addr2[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
               end
               default: begin
                  if (r.to_ds) r.addr2[GROUP_BIT] = 1'b1;
                  else r.addr1[GROUP_BIT] = 1'b1;
               end
            endcase
         end
      end
      return r;
   endfunction

   // offer one request after a random gap; predict once it is taken
   task automatic drive_request(input tracker_req_type r, input bit fixed,
                                input tracker_rsp_type want);
      int              gap;
      tracker_rsp_type predicted;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {3'b000, r.ridx, r.rssi, r.addr2, r.addr1, r.from_ds, r.to_ds,
                    r.ftype, r.is_data};
      do @(posedge clock); while (!req_tready);
      predicted = track_client(r);
      pending_rsp.push_back(fixed ? want : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_target(input logic [47:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      target_mac = value;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [47:0] target, input int gap, input int pool_size,
                            input int fresh, input int clr, input int n_items,
                            input bit stress);
      logic [MAC_W-1:0] m;
      int               k;
      wait_drained();
      set_target(target);
      max_gap = gap;
      fresh_pct = fresh;
      clear_pct = clr;
      client_pool.delete();
      for (k = 0; k < pool_size; k++) begin
         m = 48'({$urandom, $urandom});
         m[GROUP_BIT] = 1'b0;
         client_pool.push_back(m);
      end
      pool_next = (fresh != 0) ? 0 : pool_size;
      drive_request(mk_req(OP_CLEAR, 0, 0, 0, 0, '0, '0, 0, 0), 1'b0, '0);
      for (k = 0; k < n_items; k++) begin
         // long result stall, then a full drain on the request side
         if (stress && k == 20) rsp_hold_req = 1'b1;
         if (stress && k == n_items / 2) wait_drained();
         drive_request(next_random_frame(), 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      tracker_rsp_type got;
      tracker_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk_rsp(rsp_tuser, rsp_tdata[7:0], rsp_tdata[55:8], rsp_tdata[63:56],
                      rsp_tdata[72:64]);
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, got.status);
            check_field("entry_index", want.index, got.index);
            check_field("client_address", want.mac, got.mac);
            check_field("client_rssi", want.rssi, got.rssi);
            check_field("client_count", want.count, got.count);
         end
      end
   end

   // result receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            stall = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end else begin
            stall = $urandom_range(0, max_gap);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL wifi_client_tracker_table");
         $finish;
      end
   end

   // stimulus
   initial begin
      int i;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_OBSERVE;
      tbl_count = 0;
      target_mac = '0;
      max_gap = MAX_IDLE;
      rsp_hold_req = 1'b0;
      error_count = 0;
      cycle_count = 0;
      client_pool.push_back(CLIENT_A);
      pool_next = 1;

      // directed rows, target BSSID still at its reset value of zero
      directed_rows = '{
         '{mk_req(OP_READ, 0, 0, 0, 0, '0, '0, 0, 8'd0), 1,
           mk_rsp(RS_OUT_RANGE, 0, '0, 0, 0)},
         '{mk_req(OP_READ, 1, 3, 1, 1, ALL_ONES, ALL_ONES, -1, 8'd255), 1,
           mk_rsp(RS_OUT_RANGE, 255, '0, 0, 0)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 1, 0, '0, CLIENT_A, -128, 0), 1,
           mk_rsp(RS_INSERTED, 0, CLIENT_A, -128, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 0, 1, CLIENT_A, '0, 127, 255), 0, '0},
         '{mk_req(OP_OBSERVE, 0, FRAME_TYPE_DATA, 1, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, 2'd0, 1, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, 2'd1, 1, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, 2'd3, 1, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 0, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 1, 1, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 1, 0, OTHER_AP, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 0, 1, GROUP_C, '0, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_UNUSED, 1, FRAME_TYPE_DATA, 1, 0, '0, CLIENT_B, 5, 0), 1,
           mk_rsp(RS_DROPPED, 0, '0, 0, 1)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 0, 1, CLIENT_B, '0, 0, 0), 0, '0},
         '{mk_req(OP_READ, 0, 0, 0, 0, '0, '0, 0, 8'd0), 0, '0},
         '{mk_req(OP_READ, 0, 0, 0, 0, '0, '0, 0, 8'd1), 0, '0},
         '{mk_req(OP_READ, 0, 0, 0, 0, '0, '0, 0, 8'd2), 1,
           mk_rsp(RS_OUT_RANGE, 2, '0, 0, 2)},
         '{mk_req(OP_CLEAR, 1, FRAME_TYPE_DATA, 1, 0, '0, CLIENT_A, 9, 7), 1,
           mk_rsp(RS_CLEARED, 0, '0, 0, 0)},
         '{mk_req(OP_READ, 0, 0, 0, 0, '0, '0, 0, 8'd0), 1,
           mk_rsp(RS_OUT_RANGE, 0, '0, 0, 0)},
         '{mk_req(OP_OBSERVE, 1, FRAME_TYPE_DATA, 1, 0, '0, CLIENT_B, -1, 0), 1,
           mk_rsp(RS_INSERTED, 0, CLIENT_B, -1, 1)},
         '{mk_req(OP_CLEAR, 0, 0, 0, 0, '0, '0, 0, 0), 1,
           mk_rsp(RS_CLEARED, 0, '0, 0, 0)}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++)
         drive_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

      // random phases: hits with pressure, no idling, overflow, zero BSSID
      run_phase(48'({$urandom, $urandom}), MAX_IDLE, 8, 0, 2, 300, 1'b1);
      run_phase(ALL_ONES, 0, 40, 0, 2, 300, 1'b0);
      run_phase(48'({$urandom, $urandom}), MAX_IDLE, 300, 85, 0, 420, 1'b0);
      run_phase('0, MAX_IDLE, 16, 0, 2, 460, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS wifi_client_tracker_table");
      end else begin
         $display("FAIL wifi_client_tracker_table");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/wctt_pkg.sv
hdl/wctt_store.sv
hdl/wifi_client_tracker_table.sv
tb/sv/wifi_client_tracker_table_tb.sv
